FILE: rtl/csa_pkg.sv
// Shared types, constants and helpers of the cursor sprite overlay.
// Used by every module of the block; depends on nothing.
package csa_pkg;

   // Item kind carried on tuser of the request channel
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_BLEND = 1'b1
   } opcode_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_CURSOR_X      = 3'd0,
      REG_CURSOR_Y      = 3'd1,
      REG_HOT_X         = 3'd2,
      REG_HOT_Y         = 3'd3,
      REG_SPRITE_WIDTH  = 3'd4,
      REG_SPRITE_HEIGHT = 3'd5
   } csr_index_type;

   localparam int DEF_MAX_SPRITE_SIDE = 64;
   localparam int RESET_SPRITE_SIDE   = 16;

   localparam int POS_W       = 13;
   localparam int HOT_W       = 6;
   localparam int SIZE_W      = 7;
   localparam int ADDR_W      = 12;
   localparam int PIXEL_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int REQ_DATA_W  = 104;
   localparam int ALPHA_LSB   = 24;

   localparam logic [7:0] ALPHA_MAX = 8'hFF;

   // Cursor placement registers as seen by the coordinate stage
   typedef struct packed {
      logic [POS_W-1:0] cursor_x;
      logic [POS_W-1:0] cursor_y;
      logic [HOT_W-1:0] hot_x;
      logic [HOT_W-1:0] hot_y;
   } geom_type;

   // Word leaving the coordinate stage toward the sprite store
   typedef struct packed {
      opcode_type          op;
      logic                hit;
      logic [ADDR_W-1:0]   addr;
      logic [PIXEL_W-1:0]  sprite;
      logic [SIZE_W-1:0]   sx;
      logic [SIZE_W-1:0]   sy;
      logic [PIXEL_W-1:0]  bg;
   } a_word_type;

   // Word leaving the sprite store toward the blend stages
   typedef struct packed {
      logic                hit;
      logic [PIXEL_W-1:0]  sprite;
      logic [PIXEL_W-1:0]  bg;
   } c_word_type;

   // Exact floor(x / 255) for x up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

FILE: rtl/csa_coord.sv
// Input stage of the cursor sprite overlay: unpacks request words and maps
// frame coordinates into sprite coordinates. Depends on csa_pkg.
module csa_coord import csa_pkg::*; #(
   parameter int SIDE_W = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  geom_type              geom,
   input  logic [SIDE_W-1:0]     width_clamp,
   input  logic [SIDE_W-1:0]     height_clamp,
   input  logic                  c_ready,
   output logic                  a_valid,
   output a_word_type            a_word
);

   logic             a_valid_ff;
   a_word_type       a_word_ff;
   a_word_type       a_word_in;
   logic [POS_W-1:0] pix_x;
   logic [POS_W-1:0] pix_y;
   logic [14:0]      sx_raw;
   logic [14:0]      sy_raw;
   logic             in_x;
   logic             in_y;

   // Take a new word whenever this stage is empty or drains this cycle
   assign req_tready = !a_valid_ff || c_ready;

   assign pix_x = req_tdata[56:44];
   assign pix_y = req_tdata[69:57];

   // Sprite coordinates, signed 15 bit
   assign sx_raw = {2'b0, pix_x} - {2'b0, geom.cursor_x} + {9'b0, geom.hot_x};
   assign sy_raw = {2'b0, pix_y} - {2'b0, geom.cursor_y} + {9'b0, geom.hot_y};
   assign in_x = !sx_raw[14] && (32'(sx_raw[13:0]) < 32'(width_clamp));
   assign in_y = !sy_raw[14] && (32'(sy_raw[13:0]) < 32'(height_clamp));

   always_comb begin
      a_word_in.op     = opcode_type'(req_tuser);
      a_word_in.hit    = in_x && in_y;
      a_word_in.addr   = req_tdata[11:0];
      a_word_in.sprite = req_tdata[43:12];
      a_word_in.sx     = sx_raw[SIZE_W-1:0];
      a_word_in.sy     = sy_raw[SIZE_W-1:0];
      a_word_in.bg     = req_tdata[101:70];
   end

   // Hold or advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_tready) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         a_word_ff <= a_word_in;
      end
   end

   assign a_valid = a_valid_ff;
   assign a_word  = a_word_ff;

endmodule

FILE: rtl/csa_store.sv
// Sprite store of the cursor overlay: one synchronous single-port memory that
// takes loads and blend reads in arrival order. Depends on csa_pkg.
module csa_store import csa_pkg::*; #(
   parameter int MAX_SPRITE_SIDE = DEF_MAX_SPRITE_SIDE,
   parameter int SIDE_W          = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              a_valid,
   input  a_word_type        a_word,
   input  logic [SIDE_W-1:0] width_clamp,
   output logic              c_ready,
   input  logic              d_ready,
   output logic              c_valid,
   output c_word_type        c_word
);

   localparam int DEPTH = MAX_SPRITE_SIDE * MAX_SPRITE_SIDE;
   localparam int AW    = $clog2(DEPTH);

   logic [PIXEL_W-1:0] sprite_mem_ff [DEPTH];
   logic [PIXEL_W-1:0] rdata_ff;
   logic               c_valid_ff;
   logic               hit_ff;
   logic [PIXEL_W-1:0] bg_ff;
   logic               issue;
   logic               is_blend;
   logic               wr_en;
   logic               rd_en;
   logic [AW-1:0]      waddr;
   logic [AW-1:0]      raddr;

   assign c_ready  = !c_valid_ff || d_ready;
   assign issue    = a_valid && c_ready;
   assign is_blend = (a_word.op == OP_BLEND);

   // Loads and reads share the port one per cycle, so no forwarding is needed
   assign wr_en = issue && !is_blend && (32'(a_word.addr) < DEPTH);
   assign rd_en = issue && is_blend && a_word.hit;
   assign waddr = AW'(a_word.addr);
   assign raddr = AW'(a_word.sy) * AW'(width_clamp) + AW'(a_word.sx);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sprite_mem_ff[waddr] <= a_word.sprite;
      end
      if (rd_en) begin
         rdata_ff <= sprite_mem_ff[raddr];
      end
   end

   // Carry the blend sideband alongside the read data; loads leave a bubble
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= a_valid && is_blend;
      end
   end

   always_ff @(posedge clock) begin
      if (issue && is_blend) begin
         hit_ff <= a_word.hit;
         bg_ff  <= a_word.bg;
      end
   end

   assign c_valid       = c_valid_ff;
   assign c_word.hit    = hit_ff;
   assign c_word.sprite = rdata_ff;
   assign c_word.bg     = bg_ff;

endmodule

FILE: rtl/csa_blend.sv
// Blend stages of the cursor overlay: per-channel products, then divide by
// 255 into the output register. Depends on csa_pkg.
module csa_blend import csa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               c_valid,
   input  c_word_type         c_word,
   output logic               d_ready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [PIXEL_W-1:0] rsp_tdata,
   output logic               rsp_tuser
);

   logic               d_valid_ff;
   logic               cov_ff;
   logic               cov_in;
   logic [7:0]         alpha_ff;
   logic [15:0]        sum_ff [3];
   logic [15:0]        sum_in [3];
   logic [15:0]        alpha_prod_ff;
   logic [15:0]        alpha_prod_in;
   logic [PIXEL_W-1:0] bg_ff;
   logic               rsp_tvalid_ff;
   logic [PIXEL_W-1:0] rsp_tdata_ff;
   logic [PIXEL_W-1:0] rsp_tdata_in;
   logic               rsp_tuser_ff;
   logic               e_ready;
   logic [7:0]         alpha;
   logic [7:0]         inv;
   logic [7:0]         chan [3];
   logic [7:0]         out_alpha;

   assign e_ready = !rsp_tvalid_ff || rsp_tready;
   assign d_ready = !d_valid_ff || e_ready;

   assign alpha = c_word.sprite[31:24];
   assign inv   = ALPHA_MAX - alpha;
   assign cov_in = c_word.hit && (alpha != 8'd0);

   // Weighted sums per color lane: B, G, R
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = 16'(c_word.sprite[8*i +: 8]) * 16'(alpha)
                   + 16'(c_word.bg[8*i +: 8]) * 16'(inv);
      end
      alpha_prod_in = 16'(c_word.bg[31:24]) * 16'(inv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_ready) begin
         d_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (d_ready && c_valid) begin
         cov_ff        <= cov_in;
         alpha_ff      <= alpha;
         sum_ff        <= sum_in;
         alpha_prod_ff <= alpha_prod_in;
         bg_ff         <= c_word.bg;
      end
   end

   // Divide, pack, and pick blended or background pixel
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         chan[i] = div255(sum_ff[i]);
      end
      out_alpha = alpha_ff + div255(alpha_prod_ff);
      if (cov_ff) begin
         rsp_tdata_in = {out_alpha, chan[2], chan[1], chan[0]};
      end else begin
         rsp_tdata_in = bg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (e_ready) begin
         rsp_tvalid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (e_ready && d_valid_ff) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= cov_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

FILE: rtl/cursor_sprite_alpha_overlay.sv
// Top level of the cursor sprite overlay: configuration registers and the
// coordinate, sprite store and blend stages. Depends on csa_pkg.
//
// Load words (tuser 0) write one ARGB sprite pixel into the sprite store and
// return nothing; blend words (tuser 1) return one ARGB pixel with tuser set
// when the cursor was blended in. Unless the response side stalls, the block
// takes one word per clock and sustains one pixel per clock; a blend result
// passes the coordinate, store read, product and output registers. The rate
// is set by the store's single port, which serves one load or one read per
// cycle in arrival order. Sprite sizes above MAX_SPRITE_SIDE are clamped to
// it, and the store holds MAX_SPRITE_SIDE squared entries. Every store entry
// that a blend reads must have been loaded since reset; the store is not
// cleared. Write configuration only while no words are in flight.
module cursor_sprite_alpha_overlay import csa_pkg::*; #(
   parameter int MAX_SPRITE_SIDE = DEF_MAX_SPRITE_SIDE
) (
   input  logic                   clock,
   input  logic                   reset,
   // tdata: sprite_addr[11:0], sprite_pixel[43:12], pix_x[56:44],
   //        pix_y[69:57], back_pixel[101:70], zero pad[103:102]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // tuser: opcode[0]
   input  logic                   req_tuser,
   // tdata: out_pixel[31:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIXEL_W-1:0]     rsp_tdata,
   // tuser: covered[0]
   output logic                   rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SIDE_W = $clog2(MAX_SPRITE_SIDE + 1);

   logic [POS_W-1:0]  cursor_x_ff;
   logic [POS_W-1:0]  cursor_y_ff;
   logic [HOT_W-1:0]  hot_x_ff;
   logic [HOT_W-1:0]  hot_y_ff;
   logic [SIZE_W-1:0] sprite_width_ff;
   logic [SIZE_W-1:0] sprite_height_ff;
   logic [SIDE_W-1:0] width_clamp;
   logic [SIDE_W-1:0] height_clamp;
   geom_type          geom;
   logic              a_valid;
   a_word_type        a_word;
   logic              c_ready;
   logic              c_valid;
   c_word_type        c_word;
   logic              d_ready;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff      <= '0;
         cursor_y_ff      <= '0;
         hot_x_ff         <= '0;
         hot_y_ff         <= '0;
         sprite_width_ff  <= SIZE_W'(RESET_SPRITE_SIDE);
         sprite_height_ff <= SIZE_W'(RESET_SPRITE_SIDE);
      end else if (csr_we) begin
         case (csr_index)
            REG_CURSOR_X:      cursor_x_ff      <= csr_wdata[POS_W-1:0];
            REG_CURSOR_Y:      cursor_y_ff      <= csr_wdata[POS_W-1:0];
            REG_HOT_X:         hot_x_ff         <= csr_wdata[HOT_W-1:0];
            REG_HOT_Y:         hot_y_ff         <= csr_wdata[HOT_W-1:0];
            REG_SPRITE_WIDTH:  sprite_width_ff  <= csr_wdata[SIZE_W-1:0];
            REG_SPRITE_HEIGHT: sprite_height_ff <= csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp sprite size to the store side
   always_comb begin
      if (int'(sprite_width_ff) > MAX_SPRITE_SIDE) begin
         width_clamp = SIDE_W'(MAX_SPRITE_SIDE);
      end else begin
         width_clamp = SIDE_W'(sprite_width_ff);
      end
      if (int'(sprite_height_ff) > MAX_SPRITE_SIDE) begin
         height_clamp = SIDE_W'(MAX_SPRITE_SIDE);
      end else begin
         height_clamp = SIDE_W'(sprite_height_ff);
      end
   end

   assign geom.cursor_x = cursor_x_ff;
   assign geom.cursor_y = cursor_y_ff;
   assign geom.hot_x    = hot_x_ff;
   assign geom.hot_y    = hot_y_ff;

   csa_coord #(
      .SIDE_W (SIDE_W)
   ) u_coord (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .geom         (geom),
      .width_clamp  (width_clamp),
      .height_clamp (height_clamp),
      .c_ready      (c_ready),
      .a_valid      (a_valid),
      .a_word       (a_word)
   );

   csa_store #(
      .MAX_SPRITE_SIDE (MAX_SPRITE_SIDE),
      .SIDE_W          (SIDE_W)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .a_valid     (a_valid),
      .a_word      (a_word),
      .width_clamp (width_clamp),
      .c_ready     (c_ready),
      .d_ready     (d_ready),
      .c_valid     (c_valid),
      .c_word      (c_word)
   );

   csa_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .c_valid    (c_valid),
      .c_word     (c_word),
      .d_ready    (d_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A blended pixel always carries a nonzero alpha
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:ALPHA_LSB] != 8'd0)
      else $error("covered pixel with zero alpha");

   // The input stalls only when a result waits at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a waiting result");

   // No result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

FILE: tb/tb_overlay_pkg.sv
// Result scoreboard for the cursor sprite overlay testbench: keeps its own
// sprite store and register copy and predicts each blended pixel.
// Depends on csa_pkg for the item kinds and register indexes.
package tb_overlay_pkg;
   import csa_pkg::*;

   // Register indexes past the end of the map; writes to them do nothing
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;

   localparam int STORE_WORDS = DEF_MAX_SPRITE_SIDE * DEF_MAX_SPRITE_SIDE;
   localparam int REPORT_MAX  = 10;

   typedef struct {
      logic [PIXEL_W-1:0] pixel;
      logic               covered;
   } blend_result_type;

   class blend_scoreboard;
      logic [PIXEL_W-1:0] store [STORE_WORDS];
      bit                 loaded [STORE_WORDS];
      logic [POS_W-1:0]   cur_x, cur_y;
      logic [HOT_W-1:0]   hot_x, hot_y;
      logic [SIZE_W-1:0]  width_r, height_r;
      blend_result_type   expected_pixels [$];
      int                 failures;
      int                 checked;
      int                 covered_count;

      function new();
         cur_x    = '0;
         cur_y    = '0;
         hot_x    = '0;
         hot_y    = '0;
         width_r  = SIZE_W'(RESET_SPRITE_SIDE);
         height_r = SIZE_W'(RESET_SPRITE_SIDE);
         foreach (loaded[i]) loaded[i] = 1'b0;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // Saturate a programmed sprite side to what the store can hold
      function int clamp_side(logic [SIZE_W-1:0] v);
         return (v > DEF_MAX_SPRITE_SIDE) ? DEF_MAX_SPRITE_SIDE : int'(v);
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_CURSOR_X:      cur_x    = value[POS_W-1:0];
            REG_CURSOR_Y:      cur_y    = value[POS_W-1:0];
            REG_HOT_X:         hot_x    = value[HOT_W-1:0];
            REG_HOT_Y:         hot_y    = value[HOT_W-1:0];
            REG_SPRITE_WIDTH:  width_r  = value[SIZE_W-1:0];
            REG_SPRITE_HEIGHT: height_r = value[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      // Store index the frame pixel lands on, or -1 when outside the sprite
      function int sprite_index(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
         int w, h, sx, sy;
         w  = clamp_side(width_r);
         h  = clamp_side(height_r);
         sx = int'(px) - int'(cur_x) + int'(hot_x);
         sy = int'(py) - int'(cur_y) + int'(hot_y);
         if (sx >= 0 && sx < w && sy >= 0 && sy < h)
            return sy * w + sx;
         return -1;
      endfunction

      function logic [7:0] mix_channel(int unsigned c, int unsigned bg, int unsigned a);
         return 8'((c * a + bg * (255 - a)) / 255);
      endfunction

      // Expected output pixel for one frame pixel over the current sprite
      function blend_result_type blend_pixel(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                             logic [PIXEL_W-1:0] bg);
         blend_result_type r;
         int idx;
         logic [PIXEL_W-1:0] s;
         int unsigned a;
         r.pixel   = bg;
         r.covered = 1'b0;
         idx = sprite_index(px, py);
         if (idx >= 0) begin
            s = store[idx];
            a = s[31:ALPHA_LSB];
            if (a != 0) begin
               r.pixel[7:0]   = mix_channel(s[7:0], bg[7:0], a);
               r.pixel[15:8]  = mix_channel(s[15:8], bg[15:8], a);
               r.pixel[23:16] = mix_channel(s[23:16], bg[23:16], a);
               r.pixel[31:24] = 8'(a + (int'(bg[31:24]) * (255 - a)) / 255);
               r.covered      = 1'b1;
            end
         end
         return r;
      endfunction

      // Update the store on a load word, queue the pixel on a blend word
      function void note_word(opcode_type op, logic [ADDR_W-1:0] addr,
                              logic [PIXEL_W-1:0] spix, logic [POS_W-1:0] px,
                              logic [POS_W-1:0] py, logic [PIXEL_W-1:0] bg);
         if (op == OP_LOAD) begin
            store[addr]  = spix;
            loaded[addr] = 1'b1;
         end else begin
            expected_pixels.push_back(blend_pixel(px, py, bg));
         end
      endfunction

      function void check_pixel(logic [PIXEL_W-1:0] pixel, logic covered);
         blend_result_type want;
         if (expected_pixels.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("ERROR: unexpected result word pixel %h covered %b", pixel, covered);
            return;
         end
         want = expected_pixels.pop_front();
         checked++;
         if (want.covered) covered_count++;
         if (pixel !== want.pixel || covered !== want.covered) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("ERROR: result %0d: expected pixel %h covered %b, got pixel %h covered %b",
                        checked, want.pixel, want.covered, pixel, covered);
         end
      endfunction
   endclass

endpackage

FILE: tb/tb_top.sv
// Top of the cursor sprite overlay testbench: clock, reset, stream drivers,
// register writes and the end-of-run verdict.
// Depends on csa_pkg, tb_overlay_pkg and the cursor_sprite_alpha_overlay RTL.
module tb_top import csa_pkg::*, tb_overlay_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PHASES   = 9;
   localparam int PHASE_WORDS  = 155;
   localparam int DRAIN_CYCLES = 8;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [PIXEL_W-1:0]     rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   blend_scoreboard board = new();
   bit src_idle_on  = 1'b1;
   bit sink_idle_on = 1'b1;
   int words_sent   = 0;
   int settings     = 0;

   cursor_sprite_alpha_overlay dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("FAIL cursor_sprite_alpha_overlay");
      $finish;
   end

   // Result side: hold off in random bursts while idling is enabled
   initial begin
      int hold;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_idle_on && $urandom_range(0, 6) == 0) begin
            hold = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_pixel(rsp_tdata, rsp_tuser);
   end

   function automatic logic [PIXEL_W-1:0] random_sprite_pixel();
      logic [PIXEL_W-1:0] p;
      p = $urandom;
      case ($urandom_range(0, 3))
         0: p[31:24] = 8'h00;
         1: p[31:24] = 8'hFF;
         default: ;
      endcase
      return p;
   endfunction

   // Present one request word, hold it until accepted, then record it
   task automatic send_word(opcode_type op, logic [ADDR_W-1:0] addr,
                            logic [PIXEL_W-1:0] spix, logic [POS_W-1:0] px,
                            logic [POS_W-1:0] py, logic [PIXEL_W-1:0] bg);
      int hold;
      if (src_idle_on && $urandom_range(0, 5) == 0) begin
         hold = $urandom_range(1, 9);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (hold - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, bg, py, px, spix, addr};
      do @(posedge clock); while (!req_tready);
      board.note_word(op, addr, spix, px, py, bg);
      words_sent++;
   endtask

   // Blend a frame pixel, loading its sprite entry first if never written
   task automatic send_blend(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                             logic [PIXEL_W-1:0] bg);
      int idx;
      idx = board.sprite_index(px, py);
      if (idx >= 0 && !board.loaded[idx])
         send_word(OP_LOAD, ADDR_W'(idx), random_sprite_pixel(), POS_W'($urandom),
                   POS_W'($urandom), $urandom);
      send_word(OP_BLEND, ADDR_W'($urandom), $urandom, px, py, bg);
   endtask

   task automatic send_load(logic [ADDR_W-1:0] addr, logic [PIXEL_W-1:0] spix);
      send_word(OP_LOAD, addr, spix, POS_W'($urandom), POS_W'($urandom), $urandom);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(index, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(int cx, int cy, int hx, int hy, int w, int h);
      write_csr(REG_CURSOR_X, CSR_DATA_W'(cx));
      write_csr(REG_CURSOR_Y, CSR_DATA_W'(cy));
      write_csr(REG_HOT_X, CSR_DATA_W'(hx));
      write_csr(REG_HOT_Y, CSR_DATA_W'(hy));
      write_csr(REG_SPRITE_WIDTH, CSR_DATA_W'(w));
      write_csr(REG_SPRITE_HEIGHT, CSR_DATA_W'(h));
      settings++;
   endtask

   // Drop valid and wait until every blended pixel is back and the pipe is empty
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Mostly pixels around the cursor, some sprite loads, some stray pixels
   task automatic random_phase(int count);
      int start, w_c, h_c, area, offx, offy, pick;
      logic [POS_W-1:0] px, py;
      logic [ADDR_W-1:0] addr;
      start = words_sent;
      while (words_sent - start < count) begin
         w_c  = board.clamp_side(board.width_r);
         h_c  = board.clamp_side(board.height_r);
         area = w_c * h_c;
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            if (area > 0 && $urandom_range(0, 9) < 7)
               addr = ADDR_W'($urandom_range(0, area - 1));
            else
               addr = ADDR_W'($urandom);
            send_load(addr, random_sprite_pixel());
         end else if (pick < 85) begin
            offx = int'($urandom_range(0, w_c + 6)) - 3;
            offy = int'($urandom_range(0, h_c + 6)) - 3;
            px = POS_W'(int'(board.cur_x) - int'(board.hot_x) + offx);
            py = POS_W'(int'(board.cur_y) - int'(board.hot_y) + offy);
            send_blend(px, py, $urandom);
         end else begin
            send_blend(POS_W'($urandom), POS_W'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      int phase;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset geometry (16x16 sprite at the origin)
      send_load(ADDR_W'(0), 32'hFF12_3456);
      send_load(ADDR_W'(1), 32'h00AB_CDEF);
      send_load(ADDR_W'(2), 32'h01FF_FFFF);
      send_load(ADDR_W'(15), 32'hFFFF_FFFF);
      send_load(ADDR_W'(240), 32'h8000_0000);
      send_load(ADDR_W'(255), 32'h7F80_4020);
      send_word(OP_LOAD, 12'hFFF, 32'hFFFF_FFFF, 13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF);
      send_blend(13'd0, 13'd0, 32'h0000_0000);
      send_blend(13'd0, 13'd0, 32'hFFFF_FFFF);
      send_blend(13'd1, 13'd0, 32'h5A5A_A5A5);
      send_blend(13'd2, 13'd0, 32'hFFFF_FFFF);
      send_blend(13'd15, 13'd0, 32'h0000_0000);
      send_blend(13'd16, 13'd0, 32'h1234_5678);
      send_blend(13'd0, 13'd15, 32'h1234_5678);
      send_blend(13'd15, 13'd15, 32'hFFFF_FFFF);
      send_blend(13'd0, 13'd16, 32'hCAFE_F00D);
      send_blend(13'h1FFF, 13'h1FFF, 32'h8080_8080);
      settle();

      // Random phases, one register setting each
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: apply_setting(100, 37, 3, 5, 16, 16);
            1: apply_setting(8191, 8191, 63, 63, 64, 64);
            2: apply_setting(0, 0, 0, 0, 1, 1);
            3: apply_setting(0, 0, 63, 63, 64, 64);
            4: apply_setting(500, 500, 10, 2, 0, 12);
            5: apply_setting(1200, 40, 7, 0, 40, 0);
            6: apply_setting($urandom_range(0, 8191), $urandom_range(0, 8191),
                             $urandom_range(0, 63), $urandom_range(0, 63), 127, 100);
            7: apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            default: apply_setting($urandom_range(0, 8191), $urandom_range(0, 8191),
                                   $urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom_range(1, 64), $urandom_range(1, 64));
         endcase
         if (phase == 4) begin
            write_csr(REG_UNUSED_6, CSR_DATA_W'($urandom));
            write_csr(REG_UNUSED_7, CSR_DATA_W'($urandom));
         end
         if (phase == NUM_PHASES - 1) begin
            src_idle_on  = 1'b0;
            sink_idle_on = 1'b0;
         end
         random_phase(PHASE_WORDS);
         settle();
      end

      $display("Sent %0d request words under %0d register settings; checked %0d pixels",
               words_sent, settings, board.checked);
      $display("Sprite blended into %0d pixels, %0d failures", board.covered_count,
               board.failures);
      if (board.failures == 0 && board.pending() == 0)
         $display("PASS cursor_sprite_alpha_overlay");
      else
         $display("FAIL cursor_sprite_alpha_overlay");
      $finish;
   end

endmodule
